// File: sv/vt4_pkg.sv
package vt4_pkg;

    localparam int FRAC_BITS = 16;
    localparam int LANES     = 4;
    localparam int WORD_W    = 32;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int PAIR_W    = PROD_W + 1;
    localparam int SUM_W     = PROD_W + 2;
    localparam int SHIFT_W   = SUM_W - FRAC_BITS;

    localparam int NUM_REGS  = 8;
    localparam int REG_W     = 64;
    localparam int IDX_W     = $clog2(NUM_REGS);
    localparam int ADDR_LSB  = $clog2(REG_W / 8);
    localparam int ADDR_W    = IDX_W + ADDR_LSB;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_BITS - 1);

    localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [LANES-1:0][WORD_W-1:0] quad_t;
    typedef logic [NUM_REGS-1:0][REG_W-1:0] mat_t;
    typedef logic [LANES-1:0][SHIFT_W-1:0] lane_sum_t;

    localparam logic [REG_W-1:0] ONE_LOW  = REG_W'(1) << FRAC_BITS;
    localparam logic [REG_W-1:0] ONE_HIGH = REG_W'(1) << (FRAC_BITS + WORD_W);

    localparam mat_t MAT_RESET = {ONE_HIGH, {REG_W{1'b0}}, ONE_LOW, {REG_W{1'b0}},
                                  {REG_W{1'b0}}, ONE_HIGH, {REG_W{1'b0}}, ONE_LOW};

    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } pipe_ctrl_t;

endpackage

// File: sv/vt4_vec_if.sv
interface vt4_vec_if;
    import vt4_pkg::*;

    logic  valid;
    logic  ready;
    word_t vec_x;
    word_t vec_y;
    word_t vec_z;
    word_t vec_w;

    modport source (output valid, output vec_x, output vec_y, output vec_z, output vec_w,
                    input ready);
    modport sink (input valid, input vec_x, input vec_y, input vec_z, input vec_w,
                  output ready);
endinterface

// File: sv/vt4_res_if.sv
interface vt4_res_if;
    import vt4_pkg::*;

    logic  valid;
    logic  ready;
    word_t out_x;
    word_t out_y;
    word_t out_z;
    word_t out_w;
    logic  saturated;

    modport source (output valid, output out_x, output out_y, output out_z, output out_w,
                    output saturated, input ready);
    modport sink (input valid, input out_x, input out_y, input out_z, input out_w,
                  input saturated, output ready);
endinterface

// File: sv/vt4_lane.sv
module vt4_lane
    import vt4_pkg::*;
(
    input  logic                      clk,
    input  pipe_ctrl_t                ctrl,
    input  quad_t                     coef,
    input  quad_t                     vec,
    output logic signed [SHIFT_W-1:0] lane_sum
);

    logic signed [PROD_W-1:0]  prod_next [LANES];
    logic signed [PROD_W-1:0]  prod_reg  [LANES];
    logic signed [PAIR_W-1:0]  pair_next [2];
    logic signed [PAIR_W-1:0]  pair_reg  [2];
    logic signed [SUM_W-1:0]   total;
    logic signed [SHIFT_W-1:0] sum_next;
    logic signed [SHIFT_W-1:0] sum_reg;

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            prod_next[k] = word_t'(coef[k]) * word_t'(vec[k]);
        end
        pair_next[0] = PAIR_W'(prod_reg[0]) + PAIR_W'(prod_reg[1]);
        pair_next[1] = PAIR_W'(prod_reg[2]) + PAIR_W'(prod_reg[3]);
        total        = SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]) + ROUND_HALF;
        sum_next     = total[SUM_W-1:FRAC_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en1)
        begin
            prod_reg <= prod_next;
        end
        if (ctrl.en2)
        begin
            pair_reg <= pair_next;
        end
        if (ctrl.en3)
        begin
            sum_reg <= sum_next;
        end
    end

    assign lane_sum = sum_reg;

endmodule

// File: sv/vt4_merge.sv
module vt4_merge
    import vt4_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  lane_sum_t sums,
    vt4_res_if.source res
);

    word_t             comp_next [LANES];
    word_t             comp_reg  [LANES];
    logic [LANES-1:0]  clip;
    logic              valid_reg;
    logic              valid_next;
    logic              sat_reg;
    logic              load;
    logic [SHIFT_W-WORD_W:0] upper;

    always_comb
    begin
        upper = '0;
        for (int r = 0; r < LANES; r++)
        begin
            upper   = sums[r][SHIFT_W-1:WORD_W-1];
            clip[r] = !((&upper) || !(|upper));
            if (!clip[r])
            begin
                comp_next[r] = sums[r][WORD_W-1:0];
            end
            else if (sums[r][SHIFT_W-1])
            begin
                comp_next[r] = WORD_MIN;
            end
            else
            begin
                comp_next[r] = WORD_MAX;
            end
        end
    end

    assign in_ready   = !valid_reg || res.ready;
    assign load       = in_valid && in_ready;
    assign valid_next = load || (valid_reg && !res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            comp_reg <= comp_next;
            sat_reg  <= |clip;
        end
    end

    assign res.valid     = valid_reg;
    assign res.out_x     = comp_reg[0];
    assign res.out_y     = comp_reg[1];
    assign res.out_z     = comp_reg[2];
    assign res.out_w     = comp_reg[3];
    assign res.saturated = sat_reg;

endmodule

// File: sv/vertex_transform_4x4_core.sv
// channel   dir  payload                          handshake
// vec_in    in   vec_x vec_y vec_z vec_w          valid/ready
// res_out   out  out_x out_y out_z out_w sat      valid/ready
// apb       in   paddr pwdata (64b), prdata       psel/penable/pwrite, pready high
//
// one item per cycle sustained while res_out is ready; a result reaches res_out through the
// multiply, pair add, round add and saturate stage registers, in that order
// rst_n clears stage valids and loads the identity matrix
// each stage advances when the next is empty or moving, so bubbles absorb stalls
module vertex_transform_4x4_core
    import vt4_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [REG_W-1:0]  pwdata,
    output logic [REG_W-1:0]  prdata,
    output logic              pready,
    vt4_vec_if.sink           vec_in,
    vt4_res_if.source         res_out
);

    mat_t             mat_reg;
    mat_t             mat_next;
    logic [IDX_W-1:0] reg_idx;
    logic             cfg_wr;

    pipe_ctrl_t       ctrl;
    logic             v1_reg, v2_reg, v3_reg;
    logic             v1_next, v2_next, v3_next;
    logic             merge_ready;
    quad_t            vec;
    quad_t            coef [LANES];
    lane_sum_t        sums;

    assign reg_idx = paddr[ADDR_W-1:ADDR_LSB];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign prdata  = mat_reg[reg_idx];

    always_comb
    begin
        mat_next = mat_reg;
        if (cfg_wr)
        begin
            mat_next[reg_idx] = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg <= MAT_RESET;
        end
        else
        begin
            mat_reg <= mat_next;
        end
    end

    assign ctrl.en3     = !v3_reg || merge_ready;
    assign ctrl.en2     = !v2_reg || ctrl.en3;
    assign ctrl.en1     = !v1_reg || ctrl.en2;
    assign vec_in.ready = ctrl.en1;

    assign v1_next = ctrl.en1 ? vec_in.valid : v1_reg;
    assign v2_next = ctrl.en2 ? v1_reg : v2_reg;
    assign v3_next = ctrl.en3 ? v2_reg : v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    assign vec = {vec_in.vec_w, vec_in.vec_z, vec_in.vec_y, vec_in.vec_x};

    for (genvar r = 0; r < LANES; r++)
    begin : g_lane
        for (genvar k = 0; k < LANES; k++)
        begin : g_coef
            localparam int E = k * LANES + r;
            assign coef[r][k] = mat_reg[E / 2][(E % 2) * WORD_W +: WORD_W];
        end

        vt4_lane u_lane (
            .clk      (clk),
            .ctrl     (ctrl),
            .coef     (coef[r]),
            .vec      (vec),
            .lane_sum (sums[r])
        );
    end

    vt4_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v3_reg),
        .in_ready (merge_ready),
        .sums     (sums),
        .res      (res_out)
    );

endmodule
